// File: hdl/atm_pkg.sv
// shared types, constants and text tables of the at command modem interpreter
package atm_pkg;

  localparam int LINE_MAX = 60;
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int BAUD_W   = 20;
  localparam logic [BAUD_W-1:0] DEFAULT_BAUD = 20'd9600;

  // decimal conversion of the baud rate, most significant digit first
  localparam int DIG_COUNT = 7;
  localparam int DPOS_W    = 3;
  localparam logic [DPOS_W-1:0] DPOS_LAST = DPOS_W'(DIG_COUNT - 1);

  // first body byte of a dial line, after "ATD"
  localparam logic [ADDR_W-1:0] DIAL_BODY = ADDR_W'(3);

  localparam logic [1:0] OP_HOST = 2'd0;
  localparam logic [1:0] OP_DIAL = 2'd1;
  localparam logic [1:0] OP_LOST = 2'd2;

  localparam logic [1:0] DEST_HOST  = 2'd0;
  localparam logic [1:0] DEST_NET   = 2'd1;
  localparam logic [1:0] DEST_DIAL  = 2'd2;
  localparam logic [1:0] DEST_CLOSE = 2'd3;

  localparam logic [1:0] PLUS_LAST = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // response text, lines packed back to back
  localparam int TEXT_LEN = 71;
  localparam int TPTR_W   = $clog2(TEXT_LEN);
  localparam logic [TEXT_LEN*8-1:0] TEXT_ROM = {
    "OK\015\012",
    "ERROR\015\012",
    "NO CARRIER\015\012",
    "CONNECT\015\012",
    "CONNECT ",
    "VIRTUAL AT MODEM (TCP BRIDGE)\015\012"
  };

  typedef enum logic [2:0] {
    TXT_OK,
    TXT_ERROR,
    TXT_NOCARR,
    TXT_CONNECT,
    TXT_CONNECT_SP,
    TXT_CRLF,
    TXT_IDENT
  } text_id_t;

  typedef enum logic [2:0] {
    SRC_ITEM,
    SRC_PLUS,
    SRC_ZERO,
    SRC_TEXT,
    SRC_DIGIT,
    SRC_RAM
  } byte_src_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       dial_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic       carrier;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        latch_item;
    logic        emit;
    byte_src_t   src;
    logic [1:0]  dest;
    logic        finish;
    logic        mode_set;
    logic        mode_clr;
    logic        plus_inc;
    logic        plus_dec;
    logic        plus_clr;
    logic        echo_set;
    logic        echo_clr;
    logic        link_set;
    logic        link_clr;
    logic        wait_set;
    logic        wait_clr;
    logic        line_write;
    logic        line_back;
    logic        line_clr;
    logic        text_load;
    text_id_t    text_id;
    logic        text_adv;
    logic        dig_load;
    logic        dig_sub;
    logic        dig_next;
    logic        ridx_first;
    logic        ridx_body;
    logic        ridx_inc;
    logic        hdr_latch;
    logic [1:0]  hdr_idx;
    logic        scan_clear;
    logic        scan_take;
    logic        emit_clear;
    logic        emit_take;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data_byte;
    logic             dial_ok;
    logic             data_mode;
    logic [1:0]       plus_run;
    logic             echo;
    logic             link;
    logic             waiting;
    logic [LEN_W-1:0] line_len;
    logic             out_free;
    logic             text_last;
    logic             dig_ge;
    logic             dig_show;
    logic             dig_last;
    logic             is_at;
    logic             body_empty;
    logic [7:0]       letter;
    logic             e_zero;
    logic             ridx_last;
    logic             dial_empty;
    logic             dial_err;
    logic             ram_emit;
  } dp_stat_t;

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? (c - CASE_BIT) : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) || (c == CH_COMMA);
  endfunction

  function automatic logic [7:0] rom_byte(input logic [TPTR_W-1:0] idx);
    int base;
    base = (TEXT_LEN - 1 - int'(idx)) * 8;
    return TEXT_ROM[base +: 8];
  endfunction

  function automatic logic [TPTR_W-1:0] text_start(input text_id_t id);
    case (id)
      TXT_OK:         return TPTR_W'(0);
      TXT_ERROR:      return TPTR_W'(4);
      TXT_NOCARR:     return TPTR_W'(11);
      TXT_CONNECT:    return TPTR_W'(23);
      TXT_CONNECT_SP: return TPTR_W'(32);
      TXT_CRLF:       return TPTR_W'(30);
      TXT_IDENT:      return TPTR_W'(40);
      default:        return TPTR_W'(0);
    endcase
  endfunction

  function automatic logic [TPTR_W-1:0] text_end(input text_id_t id);
    case (id)
      TXT_OK:         return TPTR_W'(3);
      TXT_ERROR:      return TPTR_W'(10);
      TXT_NOCARR:     return TPTR_W'(22);
      TXT_CONNECT:    return TPTR_W'(31);
      TXT_CONNECT_SP: return TPTR_W'(39);
      TXT_CRLF:       return TPTR_W'(31);
      TXT_IDENT:      return TPTR_W'(70);
      default:        return TPTR_W'(3);
    endcase
  endfunction

  function automatic logic [BAUD_W-1:0] pow10(input logic [DPOS_W-1:0] pos);
    case (pos)
      3'd0:    return 20'd1000000;
      3'd1:    return 20'd100000;
      3'd2:    return 20'd10000;
      3'd3:    return 20'd1000;
      3'd4:    return 20'd100;
      3'd5:    return 20'd10;
      default: return 20'd1;
    endcase
  endfunction

endpackage

// File: hdl/atm_ram.sv
// generic single write port ram with registered read
module atm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/atm_datapath.sv
// datapath: modem state, line store, text and digit sources, output staging
module atm_datapath
  import atm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  in_item_t            in_data,
  input  logic                cfg_wr_en,
  input  logic [BAUD_W-1:0]   cfg_wr_data,
  input  dp_cmd_t             cmd,
  output dp_stat_t            st,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  in_item_t           item;
  logic [BAUD_W-1:0]  baud;
  logic               data_mode;
  logic [1:0]         plus_run;
  logic               echo;
  logic               link;
  logic               link_next;
  logic               waiting;
  logic [LEN_W-1:0]   line_len;

  logic [TPTR_W-1:0]  tptr;
  logic [TPTR_W-1:0]  tend;

  logic [BAUD_W-1:0]  dval;
  logic [DPOS_W-1:0]  dpos;
  logic [3:0]         dcnt;
  logic               dstarted;
  logic [BAUD_W-1:0]  dpow;

  logic [ADDR_W-1:0]  ridx;
  logic [7:0]         rdata;
  logic [7:0]         hdr [4];

  logic [LEN_W-1:0]   kept;
  logic               prefix;
  logic               have_colon;
  logic               colon_first;
  logic [LEN_W-1:0]   eidx;
  logic               rd_blank;
  logic               rd_tp;

  logic               pend_valid;
  out_item_t          pend;
  out_item_t          fresh;
  logic [7:0]         emit_byte;
  logic               out_free;

  atm_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line (
    .clk   (clk),
    .we    (cmd.line_write),
    .waddr (line_len[ADDR_W-1:0]),
    .wdata (item.data_byte),
    .raddr (ridx),
    .rdata (rdata)
  );

  assign out_free  = !out_valid || !out_stall;
  assign dpow      = pow10(dpos);
  assign rd_blank  = is_blank(rdata);
  assign rd_tp     = (upper(rdata) == CH_T) || (upper(rdata) == CH_P);
  assign link_next = cmd.link_set ? 1'b1 : (cmd.link_clr ? 1'b0 : link);

  always_comb begin
    case (cmd.src)
      SRC_ITEM:  emit_byte = item.data_byte;
      SRC_PLUS:  emit_byte = CH_PLUS;
      SRC_TEXT:  emit_byte = rom_byte(tptr);
      SRC_DIGIT: emit_byte = CH_ZERO | {4'd0, dcnt};
      SRC_RAM:   emit_byte = rdata;
      default:   emit_byte = 8'd0;
    endcase
    fresh.destination = cmd.dest;
    fresh.out_byte    = emit_byte;
    fresh.carrier     = link_next;
    fresh.last        = 1'b0;
  end

  always_comb begin
    st.op         = item.operation;
    st.data_byte  = item.data_byte;
    st.dial_ok    = item.dial_ok;
    st.data_mode  = data_mode;
    st.plus_run   = plus_run;
    st.echo       = echo;
    st.link       = link;
    st.waiting    = waiting;
    st.line_len   = line_len;
    st.out_free   = out_free;
    st.text_last  = (tptr == tend);
    st.dig_ge     = (dval >= dpow);
    st.dig_last   = (dpos == DPOS_LAST);
    st.dig_show   = dstarted || (dcnt != 4'd0) || (dpos == DPOS_LAST);
    st.is_at      = (line_len >= LEN_W'(2)) && (upper(hdr[0]) == CH_A)
                    && (upper(hdr[1]) == CH_T);
    st.body_empty = (line_len == LEN_W'(2));
    st.letter     = upper(hdr[2]);
    st.e_zero     = (line_len > LEN_W'(3)) && (hdr[3] == CH_ZERO);
    st.ridx_last  = ((LEN_W'(ridx) + LEN_W'(1)) == line_len);
    st.dial_empty = (line_len == LEN_W'(3));
    st.dial_err   = (kept == LEN_W'(prefix)) || (have_colon && colon_first);
    st.ram_emit   = !rd_blank && (eidx >= LEN_W'(prefix));
  end

  // control and mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      baud        <= '0;
      data_mode   <= 1'b0;
      plus_run    <= 2'd0;
      echo        <= 1'b1;
      link        <= 1'b0;
      waiting     <= 1'b0;
      line_len    <= '0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        baud <= cfg_wr_data;
      end
      if (cmd.mode_set) begin
        data_mode <= 1'b1;
      end else if (cmd.mode_clr) begin
        data_mode <= 1'b0;
      end
      if (cmd.plus_clr) begin
        plus_run <= 2'd0;
      end else if (cmd.plus_inc) begin
        plus_run <= plus_run + 2'd1;
      end else if (cmd.plus_dec) begin
        plus_run <= plus_run - 2'd1;
      end
      if (cmd.echo_set) begin
        echo <= 1'b1;
      end else if (cmd.echo_clr) begin
        echo <= 1'b0;
      end
      link <= link_next;
      if (cmd.wait_set) begin
        waiting <= 1'b1;
      end else if (cmd.wait_clr) begin
        waiting <= 1'b0;
      end
      if (cmd.line_clr) begin
        line_len <= '0;
      end else if (cmd.line_back) begin
        if (line_len != '0) begin
          line_len <= line_len - LEN_W'(1);
        end
      end else if (cmd.line_write) begin
        line_len <= line_len + LEN_W'(1);
      end

      // one result is held back so the final one of an item can be marked
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
        pend_valid <= 1'b1;
      end else if (cmd.finish && pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item <= in_data;
    end
    if (cmd.emit) begin
      if (pend_valid) begin
        out_data <= '{destination: pend.destination, out_byte: pend.out_byte,
                      carrier: pend.carrier, last: 1'b0};
      end
      pend <= fresh;
    end else if (cmd.finish && pend_valid) begin
      out_data <= '{destination: pend.destination, out_byte: pend.out_byte,
                    carrier: pend.carrier, last: 1'b1};
    end

    if (cmd.text_load) begin
      tptr <= text_start(cmd.text_id);
      tend <= text_end(cmd.text_id);
    end else if (cmd.text_adv) begin
      tptr <= tptr + TPTR_W'(1);
    end

    if (cmd.dig_load) begin
      dval     <= (baud == '0) ? DEFAULT_BAUD : baud;
      dpos     <= '0;
      dcnt     <= 4'd0;
      dstarted <= 1'b0;
    end else if (cmd.dig_sub) begin
      dval <= dval - dpow;
      dcnt <= dcnt + 4'd1;
    end else if (cmd.dig_next) begin
      dcnt <= 4'd0;
      dpos <= dpos + DPOS_W'(1);
      if (st.dig_show) begin
        dstarted <= 1'b1;
      end
    end

    if (cmd.ridx_first) begin
      ridx <= '0;
    end else if (cmd.ridx_body) begin
      ridx <= DIAL_BODY;
    end else if (cmd.ridx_inc) begin
      ridx <= ridx + ADDR_W'(1);
    end
    if (cmd.hdr_latch) begin
      hdr[cmd.hdr_idx] <= rdata;
    end

    // dial target, first pass: count kept bytes, note prefix and last colon
    if (cmd.scan_clear) begin
      kept        <= '0;
      prefix      <= 1'b0;
      have_colon  <= 1'b0;
      colon_first <= 1'b0;
    end else if (cmd.scan_take && !rd_blank) begin
      if (kept == '0) begin
        prefix <= rd_tp;
      end
      if (rdata == CH_COLON) begin
        have_colon  <= 1'b1;
        colon_first <= (kept == '0) || (kept == LEN_W'(prefix));
      end
      kept <= kept + LEN_W'(1);
    end

    if (cmd.emit_clear) begin
      eidx <= '0;
    end else if (cmd.emit_take && !rd_blank) begin
      eidx <= eidx + LEN_W'(1);
    end
  end

endmodule

// File: hdl/atm_control.sv
// controller state machine: sequences commands, dial parsing and responses
module atm_control
  import atm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_DATA,
    S_PLUS,
    S_NET,
    S_CMD,
    S_H0,
    S_H1,
    S_H2,
    S_H3,
    S_H4,
    S_EXEC,
    S_HANG,
    S_SA,
    S_SB,
    S_DDEC,
    S_PA,
    S_PB,
    S_TEXT,
    S_DIGIT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    AFT_FINISH,
    AFT_OK,
    AFT_DIGITS
  } after_t;

  typedef enum logic [1:0] {
    HG_NONE,
    HG_OK,
    HG_NOCARR
  } hang_t;

  state_t state, state_next;
  after_t after, after_next;
  hang_t  hang, hang_next;
  logic   hdr_read;

  assign in_stall = (state != S_IDLE);
  assign hdr_read = (state == S_H0) || (state == S_H1) || (state == S_H2) ||
                    (state == S_H3) || (state == S_H4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after <= AFT_FINISH;
      hang  <= HG_NONE;
    end else begin
      state <= state_next;
      after <= after_next;
      hang  <= hang_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.src     = SRC_ITEM;
    cmd.text_id = TXT_OK;
    state_next  = state;
    after_next  = after;
    hang_next   = hang;
    if (state == S_IDLE) begin
      if (in_valid) begin
        cmd.latch_item = 1'b1;
        state_next     = S_DISPATCH;
      end
    end else if (st.out_free || hdr_read) begin
      // steps wait while a finished result is still held at the output,
      // except the header reads, whose ram address already runs ahead
      case (state)
        S_DISPATCH: begin
          case (st.op)
            OP_HOST: state_next = st.data_mode ? S_DATA : S_CMD;
            OP_DIAL: begin
              if (!st.waiting) begin
                state_next = S_FINISH;
              end else begin
                cmd.wait_clr  = 1'b1;
                cmd.text_load = 1'b1;
                state_next    = S_TEXT;
                if (!st.dial_ok) begin
                  cmd.text_id = TXT_NOCARR;
                  after_next  = AFT_FINISH;
                end else begin
                  cmd.link_set = 1'b1;
                  cmd.mode_set = 1'b1;
                  cmd.plus_clr = 1'b1;
                  cmd.dig_load = 1'b1;
                  cmd.text_id  = TXT_CONNECT_SP;
                  after_next   = AFT_DIGITS;
                  if (st.link) begin
                    cmd.emit = 1'b1;
                    cmd.dest = DEST_CLOSE;
                    cmd.src  = SRC_ZERO;
                  end
                end
              end
            end
            OP_LOST: begin
              if (st.link) begin
                hang_next  = st.data_mode ? HG_NOCARR : HG_NONE;
                state_next = S_HANG;
              end else begin
                state_next = S_FINISH;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
        S_DATA: begin
          if (st.data_byte == CH_PLUS) begin
            if (st.plus_run == PLUS_LAST) begin
              cmd.mode_clr  = 1'b1;
              cmd.plus_clr  = 1'b1;
              cmd.text_load = 1'b1;
              cmd.text_id   = TXT_OK;
              after_next    = AFT_FINISH;
              state_next    = S_TEXT;
            end else begin
              cmd.plus_inc = 1'b1;
              state_next   = S_FINISH;
            end
          end else if (st.plus_run != 2'd0) begin
            state_next = S_PLUS;
          end else begin
            state_next = S_NET;
          end
        end
        S_PLUS: begin
          cmd.emit     = 1'b1;
          cmd.dest     = DEST_NET;
          cmd.src      = SRC_PLUS;
          cmd.plus_dec = 1'b1;
          if (st.plus_run == 2'd1) begin
            state_next = S_NET;
          end
        end
        S_NET: begin
          if (st.link) begin
            cmd.emit = 1'b1;
            cmd.dest = DEST_NET;
            cmd.src  = SRC_ITEM;
          end
          state_next = S_FINISH;
        end
        S_CMD: begin
          if (st.echo) begin
            cmd.emit = 1'b1;
            cmd.dest = DEST_HOST;
            cmd.src  = SRC_ITEM;
          end
          if (st.data_byte == CH_CR) begin
            if (st.line_len >= LEN_W'(2)) begin
              cmd.ridx_first = 1'b1;
              state_next     = S_H0;
            end else begin
              cmd.line_clr = 1'b1;
              state_next   = S_FINISH;
            end
          end else if (st.data_byte == CH_BS || st.data_byte == CH_DEL) begin
            cmd.line_back = 1'b1;
            state_next    = S_FINISH;
          end else begin
            if (st.data_byte >= CH_SPACE && st.line_len < LEN_W'(LINE_MAX)) begin
              cmd.line_write = 1'b1;
            end
            state_next = S_FINISH;
          end
        end
        // read the first four line bytes, one ram read in flight
        S_H0: begin
          cmd.ridx_inc = 1'b1;
          state_next   = S_H1;
        end
        S_H1: begin
          cmd.hdr_latch = 1'b1;
          cmd.hdr_idx   = 2'd0;
          cmd.ridx_inc  = 1'b1;
          state_next    = S_H2;
        end
        S_H2: begin
          cmd.hdr_latch = 1'b1;
          cmd.hdr_idx   = 2'd1;
          cmd.ridx_inc  = 1'b1;
          state_next    = S_H3;
        end
        S_H3: begin
          cmd.hdr_latch = 1'b1;
          cmd.hdr_idx   = 2'd2;
          cmd.ridx_inc  = 1'b1;
          state_next    = S_H4;
        end
        S_H4: begin
          cmd.hdr_latch = 1'b1;
          cmd.hdr_idx   = 2'd3;
          state_next    = S_EXEC;
        end
        S_EXEC: begin
          after_next = AFT_FINISH;
          if (!st.is_at) begin
            cmd.line_clr = 1'b1;
            state_next   = S_FINISH;
          end else if (st.body_empty) begin
            cmd.line_clr  = 1'b1;
            cmd.text_load = 1'b1;
            cmd.text_id   = TXT_OK;
            state_next    = S_TEXT;
          end else if (st.letter == CH_D) begin
            cmd.scan_clear = 1'b1;
            cmd.ridx_body  = 1'b1;
            state_next     = st.dial_empty ? S_DDEC : S_SA;
          end else begin
            cmd.line_clr  = 1'b1;
            cmd.text_load = 1'b1;
            state_next    = S_TEXT;
            case (st.letter)
              CH_H: begin
                hang_next  = HG_OK;
                state_next = S_HANG;
              end
              CH_O: begin
                if (st.link) begin
                  cmd.mode_set = 1'b1;
                  cmd.text_id  = TXT_CONNECT;
                end else begin
                  cmd.text_id = TXT_NOCARR;
                end
              end
              CH_Z: begin
                cmd.echo_set = 1'b1;
                hang_next    = HG_OK;
                state_next   = S_HANG;
              end
              CH_E: begin
                if (st.e_zero) begin
                  cmd.echo_clr = 1'b1;
                end else begin
                  cmd.echo_set = 1'b1;
                end
              end
              CH_I: begin
                cmd.text_id = TXT_IDENT;
                after_next  = AFT_OK;
              end
              CH_A: cmd.text_id = TXT_NOCARR;
              default: cmd.text_id = TXT_OK;
            endcase
          end
        end
        S_HANG: begin
          cmd.wait_clr = 1'b1;
          cmd.mode_clr = 1'b1;
          cmd.plus_clr = 1'b1;
          after_next   = AFT_FINISH;
          if (st.link) begin
            cmd.link_clr = 1'b1;
            cmd.emit     = 1'b1;
            cmd.dest     = DEST_CLOSE;
            cmd.src      = SRC_ZERO;
          end
          case (hang)
            HG_OK: begin
              cmd.text_load = 1'b1;
              cmd.text_id   = TXT_OK;
              state_next    = S_TEXT;
            end
            HG_NOCARR: begin
              cmd.text_load = 1'b1;
              cmd.text_id   = TXT_NOCARR;
              state_next    = S_TEXT;
            end
            default: state_next = S_FINISH;
          endcase
        end
        S_SA: state_next = S_SB;
        S_SB: begin
          cmd.scan_take = 1'b1;
          if (st.ridx_last) begin
            state_next = S_DDEC;
          end else begin
            cmd.ridx_inc = 1'b1;
            state_next   = S_SA;
          end
        end
        S_DDEC: begin
          if (st.dial_err) begin
            cmd.line_clr  = 1'b1;
            cmd.text_load = 1'b1;
            cmd.text_id   = TXT_ERROR;
            after_next    = AFT_FINISH;
            state_next    = S_TEXT;
          end else begin
            cmd.ridx_body  = 1'b1;
            cmd.emit_clear = 1'b1;
            state_next     = S_PA;
          end
        end
        S_PA: state_next = S_PB;
        S_PB: begin
          if (st.ram_emit) begin
            cmd.emit = 1'b1;
            cmd.dest = DEST_DIAL;
            cmd.src  = SRC_RAM;
          end
          cmd.emit_take = 1'b1;
          if (st.ridx_last) begin
            cmd.wait_set = 1'b1;
            cmd.line_clr = 1'b1;
            state_next   = S_FINISH;
          end else begin
            cmd.ridx_inc = 1'b1;
            state_next   = S_PA;
          end
        end
        S_TEXT: begin
          cmd.emit     = 1'b1;
          cmd.dest     = DEST_HOST;
          cmd.src      = SRC_TEXT;
          cmd.text_adv = 1'b1;
          if (st.text_last) begin
            case (after)
              AFT_OK: begin
                cmd.text_load = 1'b1;
                cmd.text_id   = TXT_OK;
                after_next    = AFT_FINISH;
              end
              AFT_DIGITS: state_next = S_DIGIT;
              default:    state_next = S_FINISH;
            endcase
          end
        end
        S_DIGIT: begin
          if (st.dig_ge) begin
            cmd.dig_sub = 1'b1;
          end else begin
            if (st.dig_show) begin
              cmd.emit = 1'b1;
              cmd.dest = DEST_HOST;
              cmd.src  = SRC_DIGIT;
            end
            cmd.dig_next = 1'b1;
            if (st.dig_last) begin
              cmd.text_load = 1'b1;
              cmd.text_id   = TXT_CRLF;
              after_next    = AFT_FINISH;
              state_next    = S_TEXT;
            end
          end
        end
        S_FINISH: begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/at_command_modem_interpreter.sv
// Hayes style AT command interpreter with "+++" escape, one item at a time.
// An item passes through accept, dispatch, its handling steps and finish before
// the next one can be taken. Each response text byte and each held '+' byte is a
// step of its own, as are a network byte and a hang up. A command line first reads
// its first four bytes from the line ram and then decodes it; a dial then makes two
// passes over the ram, S_SA and S_SB and then S_PA and S_PB for each target byte,
// with S_DDEC between them. A CONNECT after a dial then sends the decimal digits
// of the baud without leading zeros, found by repeated subtraction. While the output
// is stalled with a result waiting, the current step is held (the header reads run
// on). A new item is taken in the cycle after the previous one finishes, while its
// last result may still wait at the output.
module at_command_modem_interpreter
  import atm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [BAUD_W-1:0] cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  atm_control u_control (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  atm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: bench/atm_checker.sv
`timescale 1ns / 100ps
// checker for the at command modem interpreter: predicts responses and compares transfers
module atm_checker
  import atm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [BAUD_W-1:0] cfg_wr_data,
  output int                errors,
  output int                pending
);

  localparam logic [7:0] LF = 8'h0a;
  localparam int MAX_PER_ITEM = 64;

  logic [7:0]        line_mem [LINE_MAX];
  int                line_len;
  logic              data_mode;
  int                plus_cnt;
  logic              echo;
  logic              link;
  logic              waiting;
  logic [BAUD_W-1:0] baud;

  out_item_t         resp_q[$];
  int                per_item;
  int                mism;
  int                q_before;
  out_item_t         got;
  out_item_t         want;

  function automatic logic [7:0] caps(input logic [7:0] c);
    if (c >= "a" && c <= "z") return c ^ 8'h20;
    return c;
  endfunction

  task automatic emit(input logic [1:0] d, input logic [7:0] b);
    out_item_t r;
    if (per_item >= MAX_PER_ITEM) return;
    r.destination = d;
    r.out_byte = b;
    r.carrier = link;
    r.last = 1'b0;
    resp_q.push_back(r);
    per_item++;
  endtask

  task automatic emit_line(input string s);
    for (int i = 0; i < s.len(); i++) emit(DEST_HOST, s[i]);
    emit(DEST_HOST, CH_CR);
    emit(DEST_HOST, LF);
  endtask

  task automatic drop_call(input logic notify);
    waiting = 1'b0;
    data_mode = 1'b0;
    plus_cnt = 0;
    if (link) begin
      link = 1'b0;
      emit(DEST_CLOSE, 8'h00);
    end
    if (notify) emit_line("NO CARRIER");
  endtask

  // dial target starts after "ATD"
  task automatic request_dial();
    logic [7:0] tgt [LINE_MAX];
    int n;
    int first;
    int colon;
    logic c;
    n = 0;
    first = 0;
    colon = -1;
    for (int i = 3; i < line_len && n < LINE_MAX; i++) begin
      c = (line_mem[i] == " ") || (line_mem[i] >= 8'd9 && line_mem[i] <= 8'd13) ||
          (line_mem[i] == ",");
      if (!c) begin
        tgt[n] = line_mem[i];
        n++;
      end
    end
    if (n > 0 && (caps(tgt[0]) == "T" || caps(tgt[0]) == "P")) first = 1;
    for (int i = first; i < n; i++) if (tgt[i] == ":") colon = i;
    if (n == first || colon == first) begin
      emit_line("ERROR");
      return;
    end
    for (int i = first; i < n; i++) emit(DEST_DIAL, tgt[i]);
    waiting = 1'b1;
  endtask

  task automatic run_line();
    if (line_len == 2) begin
      emit_line("OK");
      return;
    end
    case (caps(line_mem[2]))
      "D": request_dial();
      "H": begin
        drop_call(1'b0);
        emit_line("OK");
      end
      "O": begin
        if (link) begin
          data_mode = 1'b1;
          emit_line("CONNECT");
        end else begin
          emit_line("NO CARRIER");
        end
      end
      "Z": begin
        drop_call(1'b0);
        echo = 1'b1;
        emit_line("OK");
      end
      "E": begin
        echo = !(line_len > 3 && line_mem[3] == "0");
        emit_line("OK");
      end
      "I": begin
        emit_line("VIRTUAL AT MODEM (TCP BRIDGE)");
        emit_line("OK");
      end
      "A": emit_line("NO CARRIER");
      default: emit_line("OK");
    endcase
  endtask

  task automatic host_char(input logic [7:0] b);
    if (data_mode) begin
      if (b == "+") begin
        plus_cnt++;
        if (plus_cnt >= 3) begin
          data_mode = 1'b0;
          plus_cnt = 0;
          emit_line("OK");
        end
        return;
      end
      while (plus_cnt > 0) begin
        emit(DEST_NET, "+");
        plus_cnt--;
      end
      if (link) emit(DEST_NET, b);
      return;
    end
    if (echo) emit(DEST_HOST, b);
    if (b == CH_CR) begin
      if (line_len >= 2 && caps(line_mem[0]) == "A" && caps(line_mem[1]) == "T") run_line();
      line_len = 0;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (line_len > 0) line_len--;
    end else if (b >= CH_SPACE && line_len < LINE_MAX) begin
      line_mem[line_len] = b;
      line_len++;
    end
  endtask

  task automatic call_result(input logic ok);
    logic had;
    if (!waiting) return;
    waiting = 1'b0;
    if (!ok) begin
      emit_line("NO CARRIER");
      return;
    end
    had = link;
    link = 1'b1;
    data_mode = 1'b1;
    plus_cnt = 0;
    if (had) emit(DEST_CLOSE, 8'h00);
    emit_line($sformatf("CONNECT %0d", (baud == 0) ? 9600 : int'(baud)));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_len = 0;
      data_mode = 1'b0;
      plus_cnt = 0;
      echo = 1'b1;
      link = 1'b0;
      waiting = 1'b0;
      baud = '0;
      mism = 0;
      resp_q.delete();
    end else begin
      if (cfg_wr_en) baud = cfg_wr_data;
      if (in_valid && !in_stall) begin
        q_before = resp_q.size();
        per_item = 0;
        case (in_data.operation)
          OP_HOST: host_char(in_data.data_byte);
          OP_DIAL: call_result(in_data.dial_ok);
          OP_LOST: if (link) drop_call(data_mode);
          default: ;
        endcase
        if (resp_q.size() > q_before) begin
          want = resp_q[resp_q.size() - 1];
          want.last = 1'b1;
          resp_q[resp_q.size() - 1] = want;
        end
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (resp_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected transfer: dest %0d byte %h carrier %b last %b",
                     got.destination, got.out_byte, got.carrier, got.last);
        end else begin
          want = resp_q.pop_front();
          if (got.destination !== want.destination || got.out_byte !== want.out_byte ||
              got.carrier !== want.carrier || got.last !== want.last) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: expected dest %0d byte %h carrier %b last %b, %s %0d %h %b %b",
                       want.destination, want.out_byte, want.carrier, want.last, "got",
                       got.destination, got.out_byte, got.carrier, got.last);
          end
        end
      end
    end
    errors <= mism;
    pending <= resp_q.size();
  end

endmodule

// File: bench/tb_at_command_modem_interpreter.sv
`timescale 1ns / 100ps
// stimulus and verdict for the at command modem interpreter
module tb_at_command_modem_interpreter;
  import atm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int LINGER = 150;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_wr_en;
  logic [BAUD_W-1:0] cfg_wr_data;
  int                errors;
  int                pending;
  int                cycles;
  int                sent;
  bit                hold_req;
  bit                quiet;
  int                baud_phase = 0;

  at_command_modem_interpreter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  atm_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // each baud phase is entered once
  function automatic bit chk_phase(input int p);
    if (baud_phase >= p) return 1'b0;
    baud_phase = p;
    return 1'b1;
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (500) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic put(input logic [1:0] op, input logic [7:0] b, input logic ok);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, data_byte: b, dial_ok: ok};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(OP_HOST, s[i], 1'($urandom_range(0, 1)));
  endtask

  function automatic string mixed_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(0, 1)) r[i] = r[i] ^ 8'h20;
    return r;
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LINGER) @(posedge clk);
  endtask

  task automatic set_baud(input logic [BAUD_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic string dial_target();
    string pool;
    string s;
    int n;
    pool = "0123456789 ,:.-ab";
    s = "";
    case ($urandom_range(0, 3))
      0: s = "T";
      1: s = "p";
      default: ;
    endcase
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(0, pool.len() - 1);
      s = {s, pool.substr(k, k)};
    end
    return s;
  endfunction

  // random bytes in data mode, with plus runs and an optional escape or link loss
  task automatic data_burst();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) put(OP_HOST, CH_PLUS, 1'($urandom_range(0, 1)));
      else put(OP_HOST, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    case ($urandom_range(0, 3))
      0: put_text("+++");
      1: put(OP_LOST, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      default: ;
    endcase
  endtask

  task automatic random_line();
    string cmds [12];
    string s;
    cmds = '{"AT", "ATH", "ATO", "ATZ", "ATE0", "ATE1", "ATE", "ATI", "ATA", "ATX1",
             "ATS0=1", "HELLO"};
    s = mixed_case(cmds[$urandom_range(0, 11)]);
    if ($urandom_range(0, 5) == 0) s = {s, "x", string'(8'(CH_BS))};
    if ($urandom_range(0, 7) == 0) s = {s, string'(8'h07)};
    put_text({s, string'(8'(CH_CR))});
  endtask

  task automatic call_sequence();
    put_text({mixed_case("ATD"), dial_target(), string'(8'(CH_CR))});
    if ($urandom_range(0, 4) == 0) put_text({"ATD", dial_target(), string'(8'(CH_CR))});
    put(OP_DIAL, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
    data_burst();
    if ($urandom_range(0, 2) == 0) begin
      put_text({"ATO", string'(8'(CH_CR))});
      data_burst();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: outcome with nothing pending, unused opcode, link loss without a link
    put(OP_DIAL, 8'hff, 1'b1);
    put(OP_SPARE, 8'h00, 1'b0);
    put(OP_LOST, 8'h00, 1'b0);
    put_text({"ATD", string'(8'(CH_CR))});
    put_text({"atdt:5", string'(8'(CH_CR))});
    put_text({"ATDp 1,2", string'(8'(CH_CR))});
    put(OP_DIAL, 8'h00, 1'b1);
    put_text("a++b++");
    put(OP_HOST, 8'hff, 1'b0);
    put_text("+++");
    put(OP_LOST, 8'h00, 1'b0);
    put_text({"ATI", string'(8'(CH_CR))});
    put_text({"ATE0", string'(8'(CH_CR))});
    put_text({"ATZ", string'(8'(CH_CR))});
    // overlong line with backspace and delete
    for (int i = 0; i < 66; i++)
      put(OP_HOST, (i == 0) ? "A" : ((i == 1) ? "T" : "7"), 1'b0);
    put(OP_HOST, CH_BS, 1'b0);
    put(OP_HOST, CH_DEL, 1'b0);
    put(OP_HOST, CH_CR, 1'b0);

    // fill the block while the receiver holds off
    hold_req = 1'b1;
    repeat (3) put_text({"ATI", string'(8'(CH_CR))});
    set_baud(20'd921600);

    while (sent < 430) begin
      int pick;
      if (sent > 250 && sent < 300) quiet = 1'b1;
      else quiet = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 4) call_sequence();
      else if (pick < 8) random_line();
      else put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
      case (sent / 100)
        1: if (chk_phase(1)) set_baud(20'd1);
        2: if (chk_phase(2)) set_baud(20'($urandom_range(2, 921599)));
        3: if (chk_phase(3)) set_baud(20'd0);
        4: if (chk_phase(4)) set_baud(20'($urandom_range(0, 921600)));
        default: ;
      endcase
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: at_command_modem_interpreter.f
hdl/atm_pkg.sv
hdl/atm_ram.sv
hdl/atm_datapath.sv
hdl/atm_control.sv
hdl/at_command_modem_interpreter.sv
bench/atm_checker.sv
bench/tb_at_command_modem_interpreter.sv
